// ----- hw/rtl/coq_pkg.sv -----
`default_nettype none

package coq_pkg;

	// Queue capacity and derived widths
	localparam int NUM_CLIENTS = 16;
	localparam int IDX_W       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int OCC_W       = $clog2(NUM_CLIENTS + 1);

	// Fixed field widths of the request and result
	localparam int OP_W     = 2;
	localparam int CLIENT_W = 4;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [CLIENT_W-1:0] client_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [OCC_W-1:0]    occ_t;

	// Operation codes
	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_LOOKUP = 2'd2;

	// Status codes
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_DUP    = 2'd1;
	localparam status_t ST_ABSENT = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	// Per-cell control from the queue controller
	typedef struct packed {
		logic occupied;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/coq_req_if.sv -----
`default_nettype none

interface coq_req_if
	import coq_pkg::*;
;
	logic    valid;
	logic    ready;
	op_t     op;
	client_t client;

	modport source (output valid, output op, output client, input ready);
	modport sink (input valid, input op, input client, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/coq_rsp_if.sv -----
`default_nettype none

interface coq_rsp_if
	import coq_pkg::*;
;
	logic    valid;
	logic    ready;
	logic    found;
	pos_t    position;
	status_t status;
	len_t    queue_length;

	modport source (output valid, output found, output position, output status,
		output queue_length, input ready);
	modport sink (input valid, input found, input position, input status,
		input queue_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/coq_cell.sv -----
`default_nettype none

module coq_cell
	import coq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire client_t   client,
	input  wire client_t   next_id,
	output client_t        id,
	output logic           match
);

	client_t id_q;

	// Take the neighbor's entry on a compacting shift, the new client on a load
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			id_q <= next_id;
		end else if (ctl.load) begin
			id_q <= client;
		end
	end

	// Compare only while this slot holds a live entry
	assign match = ctl.occupied && (id_q == client);
	assign id    = id_q;

endmodule

`default_nettype wire

// ----- hw/rtl/compacting_ordered_queue_core.sv -----
// Compacting ordered queue of unique client IDs.
// Request channel (req): op and client. Add appends the client at the tail,
// remove deletes it from any position and closes the gap, lookup only
// reports. Any other op code behaves as a lookup.
// Result channel (rsp): found, position before the request, status and the
// queue length after it. Exactly one result per request, in request order.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle unless the receiver stalls; every slot
// cell compares against the client in parallel and the cells from the hit
// on shift by one place in the same cycle, so the row update sets the rate.
// A request is taken while the result register is empty or being drained
// in the same cycle; when the receiver stalls, the held result stays put
// and req.ready drops until it is taken.
// Reset (arst_n low) empties the queue and drops any held result;
// slot contents are not cleared, since only entries below the length are
// ever read.
`default_nettype none

module compacting_ordered_queue_core
	import coq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	coq_req_if.sink    req,
	coq_rsp_if.source  rsp
);

	client_t   cell_id [NUM_CLIENTS];
	logic      cell_match [NUM_CLIENTS];
	cell_ctl_t cell_ctl [NUM_CLIENTS];

	occ_t    occupancy_q;
	logic    rsp_valid_q;
	logic    found_q;
	pos_t    position_q;
	status_t status_q;
	len_t    length_q;

	logic    take;
	logic    hit;
	idx_t    hit_pos;
	logic    do_add;
	logic    do_remove;
	status_t status_d;
	occ_t    occupancy_d;

	// Accept when the result register is free or drains this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	// Row of slot cells; each shifts from its tail-side neighbor
	for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_cell
		client_t next_id;
		if (g == NUM_CLIENTS - 1) begin : g_last
			assign next_id = cell_id[g];
		end else begin : g_mid
			assign next_id = cell_id[g+1];
		end
		coq_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[g]),
			.client  (req.client),
			.next_id (next_id),
			.id      (cell_id[g]),
			.match   (cell_match[g])
		);
	end

	// Combine the match lines; IDs are unique so at most one fires
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = 0; i < NUM_CLIENTS; i++) begin
			hit     = hit | cell_match[i];
			hit_pos = hit_pos | (cell_match[i] ? idx_t'(i) : idx_t'(0));
		end
	end

	// Decide the operation outcome
	always_comb begin
		do_add      = 1'b0;
		do_remove   = 1'b0;
		status_d    = ST_OK;
		occupancy_d = occupancy_q;
		case (req.op)
			OP_ADD: begin
				if (hit) begin
					status_d = ST_DUP;
				end else if (occupancy_q == occ_t'(NUM_CLIENTS)) begin
					status_d = ST_FULL;
				end else begin
					do_add      = take;
					occupancy_d = occupancy_q + occ_t'(1);
				end
			end
			OP_REMOVE: begin
				if (!hit) begin
					status_d = ST_ABSENT;
				end else begin
					do_remove   = take;
					occupancy_d = occupancy_q - occ_t'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Drive each cell: load at the tail, shift from the hit toward the tail
	always_comb begin
		for (int i = 0; i < NUM_CLIENTS; i++) begin
			cell_ctl[i].occupied = occ_t'(i) < occupancy_q;
			cell_ctl[i].load     = do_add && (occ_t'(i) == occupancy_q);
			cell_ctl[i].shift    = do_remove && (idx_t'(i) >= hit_pos)
				&& (occ_t'(i + 1) < occupancy_q);
		end
	end

	// Hold the queue length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (take) begin
			occupancy_q <= occupancy_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			found_q    <= hit;
			position_q <= hit ? pos_t'(hit_pos) : '0;
			status_q   <= status_d;
			length_q   <= len_t'(occupancy_d);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = found_q;
	assign rsp.position     = position_q;
	assign rsp.status       = status_q;
	assign rsp.queue_length = length_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import coq_pkg::*;

	// Spare op code; the block treats it as a lookup
	localparam op_t OP_SPARE = 2'd3;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 60;
	localparam int PHASE_ITEMS   = 80;
	localparam int DRAIN_CYCLES  = 4;

	typedef struct {
		op_t     op;
		client_t client;
	} request_t;

	typedef struct {
		logic    found;
		pos_t    position;
		status_t status;
		len_t    queue_length;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	coq_req_if req_if();
	coq_rsp_if rsp_if();

	compacting_ordered_queue_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Requests waiting to be offered and results waiting to come back
	request_t pending_requests[$];
	result_t  expected_results[$];

	// Predicted queue contents
	client_t  queue_slots [NUM_CLIENTS];
	int       queue_count;

	// Membership as seen by the request generator, used only to steer stimulus
	bit [NUM_CLIENTS-1:0] gen_member;
	int                   gen_count;

	int  tx_idle_pct;
	int  rx_stall_pct;
	bit  rx_hold;
	bit  pressure_go;
	bit  req_taken;
	bit  req_offer;

	int  cycle_count;
	int  fail_count;
	int  requests_taken;
	int  results_checked;
	int  status_seen [4];
	int  full_reached;

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Compute the result of one request and update the predicted queue
	function automatic result_t predict_queue_result(op_t op, client_t client);
		result_t r;
		int      hit_pos;
		hit_pos = -1;
		for (int i = 0; i < queue_count; i++) begin
			if (hit_pos < 0 && queue_slots[i] == client)
				hit_pos = i;
		end
		r.found    = (hit_pos >= 0);
		r.position = (hit_pos >= 0) ? pos_t'(hit_pos) : pos_t'(0);
		r.status   = ST_OK;
		if (op == OP_ADD) begin
			if (r.found) begin
				r.status = ST_DUP;
			end else if (queue_count >= NUM_CLIENTS) begin
				r.status = ST_FULL;
			end else begin
				queue_slots[queue_count] = client;
				queue_count++;
				if (queue_count == NUM_CLIENTS)
					full_reached++;
			end
		end else if (op == OP_REMOVE) begin
			if (!r.found) begin
				r.status = ST_ABSENT;
			end else begin
				for (int i = hit_pos; i + 1 < queue_count; i++)
					queue_slots[i] = queue_slots[i + 1];
				queue_count--;
			end
		end
		r.queue_length = len_t'(queue_count);
		return r;
	endfunction

	// Queue a request and track membership for the generator
	task automatic push_request(op_t op, client_t client);
		request_t rq;
		rq.op     = op;
		rq.client = client;
		pending_requests.push_back(rq);
		if (op == OP_ADD && !gen_member[client] && gen_count < NUM_CLIENTS) begin
			gen_member[client] = 1'b1;
			gen_count++;
		end else if (op == OP_REMOVE && gen_member[client]) begin
			gen_member[client] = 1'b0;
			gen_count--;
		end
	endtask

	function automatic client_t pick_client(bit want_member);
		client_t c;
		c = client_t'($urandom_range(NUM_CLIENTS - 1));
		if ((want_member && gen_count == 0) || (!want_member && gen_count == NUM_CLIENTS))
			return c;
		while (gen_member[c] != want_member)
			c = client_t'($urandom_range(NUM_CLIENTS - 1));
		return c;
	endfunction

	// Random requests that drift the queue toward a moving fill target
	task automatic push_random(int count);
		int target;
		int roll;
		target = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0)
				target = ($urandom_range(3) == 0) ? NUM_CLIENTS : $urandom_range(NUM_CLIENTS);
			roll = $urandom_range(99);
			if (roll < 8) begin
				push_request(roll[0] ? OP_SPARE : OP_LOOKUP,
					client_t'($urandom_range(NUM_CLIENTS - 1)));
			end else if (roll < 16) begin
				push_request(op_t'($urandom_range(3)), client_t'($urandom_range(NUM_CLIENTS - 1)));
			end else if (gen_count < target) begin
				push_request(OP_ADD, pick_client($urandom_range(99) < 20));
			end else if (gen_count > target) begin
				push_request(OP_REMOVE, pick_client($urandom_range(99) >= 20));
			end else begin
				push_request(roll[0] ? OP_REMOVE : OP_LOOKUP, pick_client(1'b1));
			end
		end
	endtask

	task automatic wait_requests_sent();
		while (pending_requests.size() != 0)
			@(negedge clk);
	endtask

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("mismatch on %s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Request driver: hold an offered request until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid  <= 1'b0;
			req_if.op     <= OP_ADD;
			req_if.client <= '0;
		end else begin
			req_taken = req_if.valid && req_if.ready;
			if (req_taken) begin
				expected_results.push_back(predict_queue_result(req_if.op, req_if.client));
				void'(pending_requests.pop_front());
				requests_taken++;
			end
			if (req_if.valid && !req_taken)
				req_offer = 1'b1;
			else
				req_offer = (pending_requests.size() != 0) &&
					($urandom_range(99) >= tx_idle_pct);
			req_if.valid <= req_offer;
			if (req_offer) begin
				req_if.op     <= pending_requests[0].op;
				req_if.client <= pending_requests[0].client;
			end
		end
	end

	// Result monitor: compare each taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					check_field("found", 8'(expected_results[0].found), 8'(rsp_if.found));
					check_field("position", 8'(expected_results[0].position),
						8'(rsp_if.position));
					check_field("status", 8'(expected_results[0].status), 8'(rsp_if.status));
					check_field("queue_length", 8'(expected_results[0].queue_length),
						8'(rsp_if.queue_length));
					status_seen[expected_results[0].status]++;
					void'(expected_results.pop_front());
					results_checked++;
				end
			end
			rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Long receiver hold-off so the result register fills and req.ready drops
	initial begin
		rx_hold = 1'b0;
		wait (pressure_go);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Stimulus and phase sequencing
	initial begin
		arst_n        = 1'b0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		pressure_go   = 1'b0;
		queue_count   = 0;
		gen_member    = '0;
		gen_count     = 0;
		fail_count    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty queue, fill to capacity, then edge positions
		push_request(OP_LOOKUP, 4'd5);
		push_request(OP_REMOVE, 4'd9);
		for (int c = 0; c < NUM_CLIENTS; c++)
			push_request(OP_ADD, client_t'(c));
		push_request(OP_ADD, 4'd7);
		push_request(OP_LOOKUP, 4'd15);
		push_request(OP_SPARE, 4'd3);
		push_request(OP_REMOVE, 4'd8);
		push_request(OP_REMOVE, 4'd0);
		push_request(OP_REMOVE, 4'd15);
		push_request(OP_LOOKUP, 4'd9);
		push_request(OP_REMOVE, 4'd8);
		wait_requests_sent();

		// Random phases: free flow, sparse sender, stalling receiver, both
		push_random(PHASE_ITEMS);
		wait_requests_sent();
		tx_idle_pct = 85;
		push_random(PHASE_ITEMS);
		wait_requests_sent();
		tx_idle_pct  = 0;
		rx_stall_pct = 85;
		push_random(PHASE_ITEMS);
		wait_requests_sent();
		tx_idle_pct  = 27;
		rx_stall_pct = 27;
		push_random(PHASE_ITEMS);
		wait_requests_sent();

		// Back-pressure: sender runs flat out while the receiver holds off
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		pressure_go  = 1'b1;
		push_random(PHASE_ITEMS);
		wait_requests_sent();

		// Drain outstanding results
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		$display("testbench: %0d requests taken, %0d results checked over five idle patterns",
			requests_taken, results_checked);
		$display("testbench: ok %0d, dup %0d, absent %0d, full %0d; queue filled %0d times",
			status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_ABSENT],
			status_seen[ST_FULL], full_reached);
		if (fail_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
